>>> rtl/dsa_pkg.sv
// ---------------------------------------------------------------------------
// dsa_pkg: shared types and tables for the display scanner
// Beat payloads, segment and thermometer tables, register reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package dsa_pkg;

  typedef struct packed {
    logic [13:0] pressure;
    logic [5:0]  bar_count;
    logic [1:0]  page;
    logic [3:0]  menu_number;
    logic [1:0]  edit_position;
    logic [3:0]  edit_thousands;
    logic [3:0]  edit_hundreds;
    logic [3:0]  edit_tens;
    logic [3:0]  edit_units;
  } dsa_tick_t;

  typedef struct packed {
    logic [1:0] digit_select;
    logic [7:0] bar_byte;
    logic [7:0] digit_byte;
    logic [3:0] led_bits;
  } dsa_scan_t;

  localparam logic [7:0] SEG_OF [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  localparam logic [7:0] THERMO [9] = '{
    8'h00, 8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7F, 8'hFF
  };

  localparam logic [7:0] DP_BIT = 8'h80;

  localparam logic [13:0] RST_OVER_ALARM  = 14'd9999;
  localparam logic [13:0] RST_OVER_WARN   = 14'd9999;
  localparam logic [13:0] RST_UNDER_ALARM = 14'd0;
  localparam logic [13:0] RST_UNDER_WARN  = 14'd0;
  localparam logic [7:0]  RST_GLYPH_H     = 8'h76;
  localparam logic [7:0]  RST_GLYPH_U     = 8'h3E;
  localparam logic [7:0]  RST_GLYPH_A     = 8'h77;

  // Segment pattern of a decimal digit, blank for codes above nine.
  function automatic logic [7:0] dsa_seg(input logic [3:0] d);
    logic [7:0] s;
    s = 8'h00;
    if (d < 4'd10) s = SEG_OF[d];
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dsa_blink.sv
// ---------------------------------------------------------------------------
// dsa_blink: blink phase counter
// Advances on each step, wraps at twice the half period, lit in first half.
// ---------------------------------------------------------------------------
`default_nettype none

module dsa_blink #(
  parameter int HALF_PERIOD = 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step,
  output logic      lit
);

  localparam int CW = $clog2(2 * HALF_PERIOD);
  localparam logic [CW:0] WRAP = (CW + 1)'(2 * HALF_PERIOD);
  localparam logic [CW:0] HALF = (CW + 1)'(HALF_PERIOD);

  logic [CW-1:0] cnt;
  logic [CW:0]   inc;
  logic [CW-1:0] cnt_next;

  always_comb begin
    inc = {1'b0, cnt} + 1'b1;
    if (inc >= WRAP) begin
      cnt_next = '0;
    end else begin
      cnt_next = inc[CW-1:0];
    end
    lit = ({1'b0, cnt_next} < HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (step) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/display_scan_with_alarm_bar.sv
// ---------------------------------------------------------------------------
// display_scan_with_alarm_bar: four-slot display scanner with alarm LEDs
// Drives one multiplexed slot per refresh beat: bar byte, segment byte, LEDs.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake                 Payload        Direction
//  tick     tick_valid / tick_ready   dsa_tick_t     refresh beat in
//  scan     scan_valid / scan_ready   dsa_scan_t     slot drive out
//  cfg      psel/penable/pwrite       paddr/pwdata   APB register port
//
//  One beat per cycle sustained while scan_ready stays high; each beat is held
//  in the input register until the result register is free or drains.
//  The work between the two is digit split by constant reciprocals, the
//  level compares and table lookups.
//  Synchronous reset clears the scan slot, blink counters, valids and
//  config registers to their documented defaults.
//  A stalled result holds the input register; tick_ready drops only when
//  both stages are full.
//
`default_nettype none

module display_scan_with_alarm_bar
  import dsa_pkg::*;
#(
  parameter int LED_HALF_PERIOD   = 50,
  parameter int DIGIT_HALF_PERIOD = 40
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // refresh beats in
  input  wire logic        tick_valid,
  output logic             tick_ready,
  input  wire dsa_tick_t   tick,
  // slot drive out
  output logic             scan_valid,
  input  wire logic        scan_ready,
  output dsa_scan_t        scan,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_OVER_ALARM  = 3'd0;
  localparam logic [2:0] REG_OVER_WARN   = 3'd1;
  localparam logic [2:0] REG_UNDER_ALARM = 3'd2;
  localparam logic [2:0] REG_UNDER_WARN  = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;
  localparam logic [2:0] REG_GLYPH_H     = 3'd5;
  localparam logic [2:0] REG_GLYPH_U     = 3'd6;
  localparam logic [2:0] REG_GLYPH_A     = 3'd7;

  localparam logic [1:0] PAGE_MAIN   = 2'd0;
  localparam logic [1:0] PAGE_SECOND = 2'd1;
  localparam logic [1:0] PAGE_EDIT   = 2'd2;
  localparam logic [1:0] PAGE_NONE   = 2'd3;

  localparam logic [3:0] MENU_MODE = 4'd6;

  localparam logic [1:0] SLOT_THOU = 2'd0;
  localparam logic [1:0] SLOT_HUND = 2'd1;
  localparam logic [1:0] SLOT_TENS = 2'd2;
  localparam logic [1:0] SLOT_UNIT = 2'd3;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [13:0] over_alarm_level;
  logic [13:0] over_warn_level;
  logic [13:0] under_alarm_level;
  logic [13:0] under_warn_level;
  logic        current_mode;
  logic [7:0]  glyph_h;
  logic [7:0]  glyph_u;
  logic [7:0]  glyph_a;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      over_alarm_level  <= RST_OVER_ALARM;
      over_warn_level   <= RST_OVER_WARN;
      under_alarm_level <= RST_UNDER_ALARM;
      under_warn_level  <= RST_UNDER_WARN;
      current_mode      <= 1'b0;
      glyph_h           <= RST_GLYPH_H;
      glyph_u           <= RST_GLYPH_U;
      glyph_a           <= RST_GLYPH_A;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_OVER_ALARM:  over_alarm_level  <= pwdata[13:0];
        REG_OVER_WARN:   over_warn_level   <= pwdata[13:0];
        REG_UNDER_ALARM: under_alarm_level <= pwdata[13:0];
        REG_UNDER_WARN:  under_warn_level  <= pwdata[13:0];
        REG_MODE:        current_mode      <= pwdata[0];
        REG_GLYPH_H:     glyph_h           <= pwdata[7:0];
        REG_GLYPH_U:     glyph_u           <= pwdata[7:0];
        REG_GLYPH_A:     glyph_a           <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back, zero-extended.
  always_comb begin
    unique case (cfg_idx)
      REG_OVER_ALARM:  prdata = {18'd0, over_alarm_level};
      REG_OVER_WARN:   prdata = {18'd0, over_warn_level};
      REG_UNDER_ALARM: prdata = {18'd0, under_alarm_level};
      REG_UNDER_WARN:  prdata = {18'd0, under_warn_level};
      REG_MODE:        prdata = {31'd0, current_mode};
      REG_GLYPH_H:     prdata = {24'd0, glyph_h};
      REG_GLYPH_U:     prdata = {24'd0, glyph_u};
      REG_GLYPH_A:     prdata = {24'd0, glyph_a};
      default:         prdata = 32'd0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Input register and handshake
  // -------------------------------------------------------------------------
  logic      s1_valid;
  dsa_tick_t s1;
  logic      s1_adv;

  // Move the held beat forward whenever the result register is free or drains.
  assign s1_adv     = s1_valid & (~scan_valid | scan_ready);
  assign tick_ready = ~s1_valid | s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_ready) begin
      s1_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && tick_ready) begin
      s1 <= tick;
    end
  end

  // -------------------------------------------------------------------------
  // Scan state
  // -------------------------------------------------------------------------
  logic [1:0] scan_slot;
  logic [1:0] shown_slot;
  logic       active;     // beat moves forward on a displayed page
  logic       is_mode;
  logic [1:0] slot;

  assign slot    = scan_slot;
  assign is_mode = (s1.page == PAGE_EDIT) && (s1.menu_number == MENU_MODE);
  assign active  = s1_adv && (s1.page != PAGE_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_slot  <= 2'd0;
      shown_slot <= 2'd0;
    end else if (active) begin
      shown_slot <= slot;
      scan_slot  <= slot + 2'd1;
    end
  end

  // -------------------------------------------------------------------------
  // Blink counters: each advances only on a beat that uses it
  // -------------------------------------------------------------------------
  logic led_slot;
  logic main_led_lit, second_led_lit, edit_led_lit, mode_led_lit;
  logic edit_digit_lit, mode_digit_lit;
  logic edit_hit;
  logic led_lit;

  assign led_slot = active && (slot == SLOT_TENS);
  // edited digit sits in slot 3 - edit_position
  assign edit_hit = (s1.edit_position == ~slot);

  dsa_blink #(.HALF_PERIOD(LED_HALF_PERIOD)) u_main_led (
    .clk  (clk),
    .rst  (rst),
    .step (led_slot && (s1.page == PAGE_MAIN)),
    .lit  (main_led_lit)
  );

  dsa_blink #(.HALF_PERIOD(LED_HALF_PERIOD)) u_second_led (
    .clk  (clk),
    .rst  (rst),
    .step (led_slot && (s1.page == PAGE_SECOND)),
    .lit  (second_led_lit)
  );

  dsa_blink #(.HALF_PERIOD(LED_HALF_PERIOD)) u_edit_led (
    .clk  (clk),
    .rst  (rst),
    .step (led_slot && (s1.page == PAGE_EDIT) && !is_mode),
    .lit  (edit_led_lit)
  );

  dsa_blink #(.HALF_PERIOD(LED_HALF_PERIOD)) u_mode_led (
    .clk  (clk),
    .rst  (rst),
    .step (led_slot && is_mode),
    .lit  (mode_led_lit)
  );

  dsa_blink #(.HALF_PERIOD(DIGIT_HALF_PERIOD)) u_edit_digit (
    .clk  (clk),
    .rst  (rst),
    .step (active && (s1.page == PAGE_EDIT) && !is_mode && edit_hit),
    .lit  (edit_digit_lit)
  );

  dsa_blink #(.HALF_PERIOD(DIGIT_HALF_PERIOD)) u_mode_digit (
    .clk  (clk),
    .rst  (rst),
    .step (active && is_mode && (slot == SLOT_TENS)),
    .lit  (mode_digit_lit)
  );

  always_comb begin
    case (s1.page)
      PAGE_MAIN:   led_lit = main_led_lit;
      PAGE_SECOND: led_lit = second_led_lit;
      default:     led_lit = is_mode ? mode_led_lit : edit_led_lit;
    endcase
  end

  // -------------------------------------------------------------------------
  // Decimal split of the saturated pressure. Each quotient comes straight
  // from the pressure through one reciprocal product, so the products run
  // side by side; the times-ten terms are shift-adds.
  // -------------------------------------------------------------------------
  logic [13:0] pd;
  logic [28:0] prod_k;
  logic [27:0] prod_c;
  logic [26:0] prod_d;
  logic [3:0]  q_thou;   // pd / 1000
  logic [6:0]  q_hund;   // pd / 100
  logic [9:0]  q_tens;   // pd / 10
  logic [6:0]  q_thou_x10;
  logic [9:0]  q_hund_x10;
  logic [13:0] q_tens_x10;
  logic [3:0]  d_thou, d_hund, d_tens, d_unit;

  always_comb begin
    pd     = (s1.pressure > 14'd9999) ? 14'd9999 : s1.pressure;
    prod_k = {15'd0, pd} * 29'd16778;
    prod_c = {14'd0, pd} * 28'd10486;
    prod_d = {13'd0, pd} * 27'd6554;
    q_thou = prod_k[27:24];
    q_hund = prod_c[26:20];
    q_tens = prod_d[25:16];
    q_thou_x10 = {q_thou, 3'b000} + {2'b00, q_thou, 1'b0};
    q_hund_x10 = {q_hund, 3'b000} + {2'b00, q_hund, 1'b0};
    q_tens_x10 = {1'b0, q_tens, 3'b000} + {3'b000, q_tens, 1'b0};
    d_thou = q_thou;
    d_hund = 4'(q_hund - q_thou_x10);
    d_tens = 4'(q_tens - q_hund_x10);
    d_unit = 4'(pd - q_tens_x10);
  end

  // -------------------------------------------------------------------------
  // Result for the current slot
  // -------------------------------------------------------------------------
  logic [5:0] bar_base;
  logic [5:0] bar_diff;
  logic [7:0] bar;
  logic [1:0] ovf;
  logic [1:0] lvl;        // {under, over}
  logic [7:0] dig;
  logic [3:0] ed_digit;
  logic       ed_lit;
  dsa_scan_t  result;

  always_comb begin
    // Bar window: slot 2 counts 0..8, slot 1 10..18, slot 0 20..28, slot 3 30..38.
    case (slot)
      SLOT_THOU: bar_base = 6'd20;
      SLOT_HUND: bar_base = 6'd10;
      SLOT_TENS: bar_base = 6'd0;
      default:   bar_base = 6'd30;
    endcase
    bar_diff = s1.bar_count - bar_base;
    ovf      = 2'b00;
    if (s1.bar_count < bar_base) begin
      bar = 8'h00;
    end else if (bar_diff <= 6'd8) begin
      bar = THERMO[bar_diff[3:0]];
    end else begin
      // one past the window lights the first overflow LED, beyond that both
      bar = 8'hFF;
      ovf = (bar_diff == 6'd9) ? 2'b01 : 2'b11;
    end

    // Level compares on the raw value; slot 2 carries the page blink LED.
    lvl = 2'b00;
    case (slot)
      SLOT_THOU: begin
        lvl[0] = (s1.pressure >= over_alarm_level);
        lvl[1] = (s1.pressure <= under_alarm_level);
      end
      SLOT_HUND: begin
        lvl[0] = (s1.pressure >= over_warn_level) && (s1.pressure < over_alarm_level);
        lvl[1] = (s1.pressure > under_alarm_level) && (s1.pressure <= under_warn_level);
      end
      SLOT_TENS: begin
        lvl[1] = led_lit;
      end
      default: ;
    endcase

    case (slot)
      SLOT_THOU: ed_digit = s1.edit_thousands;
      SLOT_HUND: ed_digit = s1.edit_hundreds;
      SLOT_TENS: ed_digit = s1.edit_tens;
      default:   ed_digit = s1.edit_units;
    endcase
    ed_lit = edit_hit ? edit_digit_lit : 1'b1;

    dig = 8'h00;
    case (s1.page)
      PAGE_MAIN: begin
        case (slot)
          SLOT_THOU: dig = (pd > 14'd999) ? SEG_OF[d_thou] : 8'h00;
          SLOT_HUND: dig = SEG_OF[d_hund] | DP_BIT;
          SLOT_TENS: dig = SEG_OF[d_tens];
          default:   dig = SEG_OF[d_unit];
        endcase
      end
      PAGE_SECOND: begin
        if (slot == SLOT_TENS) begin
          dig = glyph_h;
        end else if (slot == SLOT_UNIT) begin
          dig = dsa_seg(s1.menu_number);
        end
      end
      default: begin
        if (is_mode) begin
          if ((slot == SLOT_TENS) && mode_digit_lit) begin
            dig = current_mode ? glyph_a : glyph_u;
          end
        end else begin
          dig = ed_lit ? dsa_seg(ed_digit) : 8'h00;
          // hundreds keeps its decimal point even while blanked
          if (slot == SLOT_HUND) dig = dig | DP_BIT;
        end
      end
    endcase

    if (s1.page == PAGE_NONE) begin
      // blank page: repeat the last driven slot, hold the scan
      result.digit_select = shown_slot;
      result.bar_byte     = 8'h00;
      result.digit_byte   = 8'h00;
      result.led_bits     = 4'h0;
    end else begin
      result.digit_select = slot;
      result.bar_byte     = bar;
      result.digit_byte   = dig;
      result.led_bits     = {lvl, ovf};
    end
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else if (s1_adv) begin
      scan_valid <= 1'b1;
    end else if (scan_ready) begin
      scan_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      scan <= result;
    end
  end

endmodule

`default_nettype wire
